@@ design/csq_pkg.sv @@
package csq_pkg;

  // Payload widths fixed by the channel format
  localparam int OPCODE_W  = 1;
  localparam int TID_W     = 8;
  localparam int OUTCOME_W = 3;
  localparam int COUNT_W   = 17;
  localparam int CFG_W     = 16;

  // Default sizing
  localparam int DEF_QUEUE_SLOTS = 64;
  localparam int DEF_ID_BITS     = 8;

  // Request codes
  localparam logic [OPCODE_W-1:0] OP_WAIT   = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_SIGNAL = 1'b1;

  // Result codes
  localparam logic [OUTCOME_W-1:0] OUT_GRANTED   = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_BLOCKED   = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_NO_WAITER = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_RESUME    = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd4;

  // Count ceiling
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 17'sd65535;

  // Control sequencer
  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

endpackage

@@ design/csq_req_if.sv @@
interface csq_req_if;
  logic                               valid;
  logic                               ready;
  logic [csq_pkg::OPCODE_W-1:0]       opcode;
  logic [csq_pkg::TID_W-1:0]          thread_id;

  modport source (output valid, output opcode, output thread_id, input ready);
  modport sink   (input valid, input opcode, input thread_id, output ready);
endinterface

@@ design/csq_rsp_if.sv @@
interface csq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [csq_pkg::OUTCOME_W-1:0]      outcome;
  logic [csq_pkg::TID_W-1:0]          resume_id;
  logic signed [csq_pkg::COUNT_W-1:0] count_now;

  modport source (output valid, output outcome, output resume_id, output count_now,
                  input ready);
  modport sink   (input valid, input outcome, input resume_id, input count_now,
                  output ready);
endinterface

@@ design/counting_semaphore_wait_queue.sv @@
// Counting semaphore with a FIFO of blocked thread IDs.
// in_chan carries requests (opcode: wait or signal, thread_id); out_chan
// returns exactly one word per request: outcome, resume_id, count_now.
// cfg_we/cfg_data load the count and empty the wait queue; write it only
// while no request is outstanding.
// Results: each result is held in the output register; when a signal wakes
// a waiter, the queued ID is first read through the waiter store's registered
// read port and is then loaded into the output register.
// Throughput: one request per cycle while out_chan is not stalled; a
// waking signal holds in_chan.ready low while the store read completes.
// Reset clears the count to zero, empties the queue and drops any pending
// result; the store contents are not cleared.
// A stalled receiver holds the result in the output register; a new
// request is still taken in the cycle the held word is taken.
module counting_semaphore_wait_queue #(
  parameter int QUEUE_SLOTS = csq_pkg::DEF_QUEUE_SLOTS,
  parameter int ID_BITS     = csq_pkg::DEF_ID_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [csq_pkg::CFG_W-1:0]   cfg_data,
  csq_req_if.sink                     in_chan,
  csq_rsp_if.source                   out_chan
);

  localparam int PTR_W       = $clog2(QUEUE_SLOTS);
  localparam int CntFloorInt = -QUEUE_SLOTS;
  localparam logic signed [csq_pkg::COUNT_W-1:0] CNT_FLOOR =
    csq_pkg::COUNT_W'(CntFloorInt);
  localparam logic signed [csq_pkg::COUNT_W-1:0] CNT_ONE = 17'sd1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);

  csq_pkg::state_t state_r, state_nxt;

  logic signed [csq_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0]                   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]                   rd_ptr_r, rd_ptr_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [csq_pkg::OUTCOME_W-1:0]      out_outcome_r, out_outcome_nxt;
  logic [csq_pkg::TID_W-1:0]          out_resume_r, out_resume_nxt;
  logic signed [csq_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic                               in_ready;
  logic                               accept;
  logic                               is_wait;
  logic                               queue_full;
  logic                               push;
  logic                               pop;
  logic [csq_pkg::OUTCOME_W-1:0]      req_outcome;
  logic signed [csq_pkg::COUNT_W-1:0] req_count;
  logic [ID_BITS-1:0]                 store_rd_data;

  assign accept     = in_chan.valid && in_ready;
  assign is_wait    = (in_chan.opcode == csq_pkg::OP_WAIT);
  assign queue_full = (cnt_r <= CNT_FLOOR);

  // Decide the request's outcome and new count
  always_comb begin
    req_outcome = csq_pkg::OUT_NO_WAITER;
    req_count   = cnt_r;
    push        = 1'b0;
    pop         = 1'b0;
    if (is_wait) begin
      if (cnt_r > 0) begin
        req_outcome = csq_pkg::OUT_GRANTED;
        req_count   = cnt_r - CNT_ONE;
      end else if (queue_full) begin
        req_outcome = csq_pkg::OUT_FULL;
      end else begin
        req_outcome = csq_pkg::OUT_BLOCKED;
        req_count   = cnt_r - CNT_ONE;
        push        = 1'b1;
      end
    end else begin
      if (cnt_r < 0) begin
        req_outcome = csq_pkg::OUT_RESUME;
        req_count   = cnt_r + CNT_ONE;
        pop         = 1'b1;
      end else if (cnt_r < csq_pkg::COUNT_MAX) begin
        req_count   = cnt_r + CNT_ONE;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csq_pkg::ST_IDLE: begin
        if (accept && pop) begin
          state_nxt = csq_pkg::ST_FETCH;
        end
      end
      csq_pkg::ST_FETCH: state_nxt = csq_pkg::ST_IDLE;
      default:           state_nxt = csq_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    unique case (state_r)
      csq_pkg::ST_IDLE:  in_ready = !out_valid_r || out_chan.ready;
      csq_pkg::ST_FETCH: in_ready = 1'b0;
      default:           in_ready = 1'b0;
    endcase
  end

  // Count and ring pointers
  always_comb begin
    cnt_nxt    = cnt_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (cfg_we) begin
      cnt_nxt    = $signed({1'b0, cfg_data});
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
    end else if (accept) begin
      cnt_nxt = req_count;
      if (push) begin
        wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Output register: load a finished word, drop it once taken
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_outcome_nxt = out_outcome_r;
    out_resume_nxt  = out_resume_r;
    out_count_nxt   = out_count_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == csq_pkg::ST_FETCH) begin
      out_valid_nxt   = 1'b1;
      out_outcome_nxt = csq_pkg::OUT_RESUME;
      out_resume_nxt  = csq_pkg::TID_W'(store_rd_data);
      out_count_nxt   = cnt_r;
    end else if (accept && !pop) begin
      out_valid_nxt   = 1'b1;
      out_outcome_nxt = req_outcome;
      out_resume_nxt  = '0;
      out_count_nxt   = req_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csq_pkg::ST_IDLE;
      cnt_r       <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_outcome_r <= out_outcome_nxt;
    out_resume_r  <= out_resume_nxt;
    out_count_r   <= out_count_nxt;
  end

  // Waiter ring
  csq_store #(
    .SLOTS  (QUEUE_SLOTS),
    .DATA_W (ID_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && push),
    .wr_addr (wr_ptr_r),
    .wr_data (ID_BITS'(in_chan.thread_id)),
    .rd_en   (accept && pop),
    .rd_addr (rd_ptr_r),
    .rd_data (store_rd_data)
  );

  assign in_chan.ready      = in_ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.outcome   = out_outcome_r;
  assign out_chan.resume_id = out_resume_r;
  assign out_chan.count_now = out_count_r;

  // The fetch state is always followed by idle
  a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == csq_pkg::ST_FETCH |=> state_r == csq_pkg::ST_IDLE)
    else $error("fetch state held longer than one cycle");

  // Output register is free when the woken ID arrives
  a_fetch_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == csq_pkg::ST_FETCH |-> !out_valid_r)
    else $error("result register busy during fetch");

  // Count never drops below minus the queue depth
  a_count_floor: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= CNT_FLOOR)
    else $error("count below queue floor");

  // A waking signal prepares its resume word for the output register in the cycle after it is accepted
  a_resume_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && pop |=> out_valid_nxt && out_outcome_nxt == csq_pkg::OUT_RESUME)
    else $error("resume word not produced after fetch");

endmodule

@@ design/csq_store.sv @@
module csq_store #(
  parameter int SLOTS  = csq_pkg::DEF_QUEUE_SLOTS,
  parameter int DATA_W = csq_pkg::DEF_ID_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [SLOTS];
  logic [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
